/* src/aws_pkg.sv */
// Shared types and constants for the anagram window search block.
package aws_pkg;

	// Fixed field widths of the item and result channels
	localparam int unsigned ACT_W    = 2;
	localparam int unsigned SYM_W_IN = 8;
	localparam int unsigned SYM_VALS = 256;
	localparam int unsigned START_W  = 32;

	// Window counts wrap like a 16-bit counter
	localparam int unsigned WCNT_W   = 16;

	// Depth of the queue between front and back
	localparam int unsigned Q_DEPTH  = 2;

	// Action codes on the input channel
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TEXT  = 2'd2;

	// Operation handed from front to back
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_TEXT  = 2'd2,
		OP_NONE  = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [SYM_W_IN-1:0]   ent_sym;
		logic [SYM_W_IN-1:0]   lv_sym;
		logic                  remove;
		logic                  check;
		logic                  status;
		logic [START_W-1:0]    start;
	} op_t;

endpackage

/* src/aws_front.sv */
// Front end: accepts items, folds symbols, tracks lengths and positions, owns the byte ring.
module aws_front import aws_pkg::*; #(
	parameter int PATTERN_MAX = 64,
	parameter int ALPHABET    = 256,
	parameter int POS_WIDTH   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACT_W-1:0]    action,
	input  logic [SYM_W_IN-1:0] symbol,
	output logic                op_valid,
	input  logic                op_ready,
	output op_t                 op
);

	localparam int RING_AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int PLEN_W  = $clog2(PATTERN_MAX + 1);
	localparam int FILL_W  = $clog2(PATTERN_MAX + 2);
	localparam int BACK_W  = $clog2(2 * PATTERN_MAX + 1);

	// Build the symbol fold table at elaboration
	function automatic logic [SYM_VALS*SYM_W_IN-1:0] fold_tbl_f();
		logic [SYM_VALS*SYM_W_IN-1:0] t;
		t = '0;
		for (int i = 0; i < SYM_VALS; i++) begin
			t[i*SYM_W_IN +: SYM_W_IN] = SYM_W_IN'(i % ALPHABET);
		end
		return t;
	endfunction

	localparam logic [SYM_VALS*SYM_W_IN-1:0] FOLD_TBL = fold_tbl_f();

	logic                 acc;
	logic [SYM_W_IN-1:0]  sym_f;
	logic [PLEN_W-1:0]    pat_len_q;
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_nx;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] start_pos;
	logic [RING_AW-1:0]   slot_q;
	logic [RING_AW-1:0]   slot_nx;
	logic [RING_AW-1:0]   back_idx;
	logic [BACK_W-1:0]    back_sum;
	logic                 full;
	logic                 remove;
	logic                 check;
	logic                 f_vld_s1;
	op_t                  op_nx;
	op_t                  f_op_s1;
	logic [SYM_W_IN-1:0]  ring_rd_s1;
	logic [SYM_W_IN-1:0]  ring_mem [PATTERN_MAX];

	assign acc      = in_valid && in_ready;
	assign in_ready = !f_vld_s1 || op_ready;
	assign sym_f    = FOLD_TBL[symbol * SYM_W_IN +: SYM_W_IN];

	// Window bookkeeping for the next text byte
	always_comb begin
		full    = (pat_len_q == PLEN_W'(PATTERN_MAX));
		remove  = (pat_len_q != '0) && (fill_q >= FILL_W'(pat_len_q));
		fill_nx = fill_q;
		if (!remove && fill_q != FILL_W'(PATTERN_MAX + 1)) begin
			fill_nx = fill_q + 1'b1;
		end
		check    = (pat_len_q != '0) && (fill_nx == FILL_W'(pat_len_q));
		back_sum = BACK_W'(slot_q) + BACK_W'(PATTERN_MAX) - BACK_W'(pat_len_q);
		if (back_sum >= BACK_W'(PATTERN_MAX)) begin
			back_sum = back_sum - BACK_W'(PATTERN_MAX);
		end
		back_idx  = RING_AW'(back_sum);
		slot_nx   = (slot_q == RING_AW'(PATTERN_MAX - 1) || pos_q == '1) ? '0 : slot_q + 1'b1;
		start_pos = pos_q + POS_WIDTH'(1) - POS_WIDTH'(pat_len_q);
	end

	// Classify the item into an operation for the back end
	always_comb begin
		op_nx      = '0;
		op_nx.kind = OP_NONE;
		case (action)
			ACT_CLEAR: begin
				op_nx.kind = OP_CLEAR;
			end
			ACT_LOAD: begin
				op_nx.kind    = full ? OP_NONE : OP_LOAD;
				op_nx.status  = full;
				op_nx.ent_sym = sym_f;
			end
			ACT_TEXT: begin
				op_nx.kind    = OP_TEXT;
				op_nx.ent_sym = sym_f;
				op_nx.remove  = remove;
				op_nx.check   = check;
				op_nx.start   = START_W'(start_pos);
			end
			default: begin
				op_nx.kind = OP_NONE;
			end
		endcase
	end

	// Advance lengths, fill and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_s1  <= 1'b0;
			pat_len_q <= '0;
			fill_q    <= '0;
			pos_q     <= '0;
			slot_q    <= '0;
		end else begin
			if (acc) begin
				f_vld_s1 <= 1'b1;
			end else if (op_ready) begin
				f_vld_s1 <= 1'b0;
			end
			if (acc) begin
				case (action)
					ACT_CLEAR: begin
						pat_len_q <= '0;
						fill_q    <= '0;
						pos_q     <= '0;
						slot_q    <= '0;
					end
					ACT_LOAD: begin
						if (!full) begin
							pat_len_q <= pat_len_q + 1'b1;
						end
					end
					ACT_TEXT: begin
						fill_q <= fill_nx;
						pos_q  <= pos_q + 1'b1;
						slot_q <= slot_nx;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Hold the classified item and the leaving byte
	always_ff @(posedge clk) begin
		if (acc) begin
			f_op_s1    <= op_nx;
			ring_rd_s1 <= ring_mem[back_idx];
		end
	end

	// Store each text byte in the ring
	always_ff @(posedge clk) begin
		if (acc && action == ACT_TEXT) begin
			ring_mem[slot_q] <= sym_f;
		end
	end

	always_comb begin
		op        = f_op_s1;
		op.lv_sym = ring_rd_s1;
	end

	assign op_valid = f_vld_s1;

endmodule

/* src/aws_queue.sv */
// Short operation queue between the front and back ends.
module aws_queue import aws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW = $clog2(Q_DEPTH + 1);

	op_t            q_mem [Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = (cnt_q != QCW'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_op     = q_mem[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_op;
		end
	end

endmodule

/* src/aws_back.sv */
// Back end: histogram memory, differing-symbol count and the result register.
module aws_back import aws_pkg::*; #(
	parameter int PATTERN_MAX = 64,
	parameter int ALPHABET    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  op_t                op,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               match,
	output logic [START_W-1:0] start_index,
	output logic               status
);

	localparam int SYM_W  = $clog2(ALPHABET);
	localparam int PCNT_W = $clog2(PATTERN_MAX + 1);
	localparam int WORD_W = PCNT_W + WCNT_W;
	localparam int DIF_W  = $clog2(ALPHABET + 1);

	// Step the differing count by one symbol's change
	function automatic logic [DIF_W-1:0] upd_f(input logic [DIF_W-1:0] d, input logic was,
		input logic now);
		logic [DIF_W-1:0] r;
		r = d;
		if (was && !now) begin
			r = d - 1'b1;
		end else if (!was && now) begin
			r = d + 1'b1;
		end
		return r;
	endfunction

	logic [WORD_W-1:0]  hist_mem [ALPHABET];
	logic [ALPHABET-1:0] hv_q;

	logic               b_vld_s1;
	op_t                op_s1;
	logic [WORD_W-1:0]  rd_lv_s1;
	logic [WORD_W-1:0]  rd_en_s1;
	logic [DIF_W-1:0]   diff_q;
	logic               lw_vld_q;
	logic [SYM_W-1:0]   lw_addr_q;
	logic [WORD_W-1:0]  lw_data_q;
	logic               pend_vld_q;
	logic [SYM_W-1:0]   pend_addr_q;
	logic [WORD_W-1:0]  pend_data_q;
	logic               out_vld_q;
	logic               match_q;
	logic [START_W-1:0] start_q;
	logic               status_q;

	logic               fire;
	logic               issue;
	logic               two_wr;
	logic [SYM_W-1:0]   lv_a;
	logic [SYM_W-1:0]   en_a;
	logic [SYM_W-1:0]   lv_a_s1;
	logic [SYM_W-1:0]   en_a_s1;
	logic [WORD_W-1:0]  lv_word;
	logic [WORD_W-1:0]  en_word0;
	logic [WORD_W-1:0]  en_word;
	logic [PCNT_W-1:0]  lv_p;
	logic [WCNT_W-1:0]  lv_w;
	logic [WCNT_W-1:0]  lv_w1;
	logic [PCNT_W-1:0]  en_p;
	logic [PCNT_W-1:0]  en_p1;
	logic [WCNT_W-1:0]  en_w;
	logic [WCNT_W-1:0]  en_w1;
	logic [DIF_W-1:0]   diff1;
	logic [DIF_W-1:0]   diff2;
	logic [DIF_W-1:0]   diff_ld;
	logic [DIF_W-1:0]   diff_nx;
	logic               wr_now;
	logic [SYM_W-1:0]   wr_addr_now;
	logic [WORD_W-1:0]  wr_data_now;
	logic               wr_en;
	logic [SYM_W-1:0]   wr_addr;
	logic [WORD_W-1:0]  wr_data;
	logic               res_match;

	assign lv_a    = op.lv_sym[SYM_W-1:0];
	assign en_a    = op.ent_sym[SYM_W-1:0];
	assign lv_a_s1 = op_s1.lv_sym[SYM_W-1:0];
	assign en_a_s1 = op_s1.ent_sym[SYM_W-1:0];

	// Fire when the result register can take the result
	assign fire     = b_vld_s1 && (!out_vld_q || out_ready);
	assign two_wr   = (op_s1.kind == OP_TEXT) && op_s1.remove;
	assign op_ready = (!b_vld_s1 || fire) && !(fire && two_wr);
	assign issue    = op_valid && op_ready;

	// Resolve entries: last write first, then valid flag, then memory
	always_comb begin
		if (lw_vld_q && lw_addr_q == lv_a_s1) begin
			lv_word = lw_data_q;
		end else begin
			lv_word = hv_q[lv_a_s1] ? rd_lv_s1 : '0;
		end
		if (lw_vld_q && lw_addr_q == en_a_s1) begin
			en_word0 = lw_data_q;
		end else begin
			en_word0 = hv_q[en_a_s1] ? rd_en_s1 : '0;
		end
	end

	// Update counts for the leaving and entering bytes
	always_comb begin
		lv_p  = lv_word[WORD_W-1:WCNT_W];
		lv_w  = lv_word[WCNT_W-1:0];
		lv_w1 = (lv_w != '0) ? lv_w - 1'b1 : lv_w;
		diff1 = diff_q;
		if (two_wr) begin
			diff1 = upd_f(diff_q, lv_w != WCNT_W'(lv_p), lv_w1 != WCNT_W'(lv_p));
		end
		en_word = (two_wr && lv_a_s1 == en_a_s1) ? {lv_p, lv_w1} : en_word0;
		en_p    = en_word[WORD_W-1:WCNT_W];
		en_w    = en_word[WCNT_W-1:0];
		en_w1   = en_w + 1'b1;
		en_p1   = en_p + 1'b1;
		diff2   = upd_f(diff1, en_w != WCNT_W'(en_p), en_w1 != WCNT_W'(en_p));
		diff_ld = upd_f(diff_q, en_w != WCNT_W'(en_p), en_w != WCNT_W'(en_p1));
	end

	// Pick the new count, the first write and the result
	always_comb begin
		diff_nx     = diff_q;
		wr_now      = 1'b0;
		wr_addr_now = en_a_s1;
		wr_data_now = {en_p, en_w1};
		res_match   = 1'b0;
		case (op_s1.kind)
			OP_CLEAR: begin
				diff_nx = '0;
			end
			OP_LOAD: begin
				diff_nx     = diff_ld;
				wr_now      = 1'b1;
				wr_data_now = {en_p1, en_w};
			end
			OP_TEXT: begin
				diff_nx = diff2;
				wr_now  = 1'b1;
				if (two_wr) begin
					wr_addr_now = lv_a_s1;
					wr_data_now = {lv_p, lv_w1};
				end
				res_match = op_s1.check && (diff2 == '0);
			end
			default: begin
			end
		endcase
	end

	// Share the write port between the first and the held second write
	always_comb begin
		wr_en   = (fire && wr_now) || pend_vld_q;
		wr_addr = (fire && wr_now) ? wr_addr_now : pend_addr_q;
		wr_data = (fire && wr_now) ? wr_data_now : pend_data_q;
	end

	// Histogram memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1    <= op;
			rd_lv_s1 <= hist_mem[lv_a];
			rd_en_s1 <= hist_mem[en_a];
		end
	end

	// Hold last and pending write data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_addr_q <= wr_addr;
			lw_data_q <= wr_data;
		end
		if (fire && two_wr) begin
			pend_addr_q <= en_a_s1;
			pend_data_q <= {en_p, en_w1};
		end
		if (fire) begin
			match_q  <= res_match;
			start_q  <= res_match ? op_s1.start : '0;
			status_q <= op_s1.status;
		end
	end

	// Control state; clear drops every entry at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_vld_s1   <= 1'b0;
			diff_q     <= '0;
			hv_q       <= '0;
			lw_vld_q   <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (issue) begin
				b_vld_s1 <= 1'b1;
			end else if (fire) begin
				b_vld_s1 <= 1'b0;
			end
			if (fire) begin
				diff_q <= diff_nx;
			end
			pend_vld_q <= fire && two_wr;
			if (wr_en) begin
				hv_q[wr_addr] <= 1'b1;
				lw_vld_q      <= 1'b1;
			end
			if (fire && op_s1.kind == OP_CLEAR) begin
				hv_q     <= '0;
				lw_vld_q <= 1'b0;
			end
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_vld_q;
	assign match       = match_q;
	assign start_index = start_q;
	assign status      = status_q;

endmodule

/* src/anagram_window_search.sv */
// Top level of the sliding-window anagram search block.
//
// Input channel (in_valid/in_ready): one item per handshake, action plus symbol.
//   Clear empties both histograms and restarts the text position, load adds a
//   pattern byte, text slides the window by one byte; every item yields one result.
// Output channel (out_valid/out_ready): match, start_index of the matching
//   window (zero without a match) and status (load ignored, pattern full).
// An item passes the front register, the queue, the back-end stage and the output register.
// Text items that slide a full window hold off the next item in the back end, set by
//   the single write port of the histogram memory (leaving and entering byte are
//   written in turn); other text items, clear, load and unused actions do not.
// The front end accepts one item per cycle while the two-entry queue has room, so it
//   keeps taking items while the back end works or a result waits.
// Reset: arst_n clears all control state; the histograms read as zero through
//   per-entry valid flags, so no clearing pass is needed and items are taken
//   as soon as reset is released.
// Receiver stall: the result waits in the output register, the back end halts,
//   the queue fills and in_ready drops.
module anagram_window_search import aws_pkg::*; #(
	parameter int PATTERN_MAX = 64,
	parameter int ALPHABET    = 256,
	parameter int POS_WIDTH   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACT_W-1:0]    action,
	input  logic [SYM_W_IN-1:0] symbol,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                match,
	output logic [START_W-1:0]  start_index,
	output logic                status
);

	logic f_valid;
	logic f_ready;
	op_t  f_op;
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	aws_front #(
		.PATTERN_MAX (PATTERN_MAX),
		.ALPHABET    (ALPHABET),
		.POS_WIDTH   (POS_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.symbol   (symbol),
		.op_valid (f_valid),
		.op_ready (f_ready),
		.op       (f_op)
	);

	aws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_op     (b_op)
	);

	aws_back #(
		.PATTERN_MAX (PATTERN_MAX),
		.ALPHABET    (ALPHABET)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (b_valid),
		.op_ready    (b_ready),
		.op          (b_op),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.match       (match),
		.start_index (start_index),
		.status      (status)
	);

endmodule

/* src/aws_checker.sv */
// Port-level checker for the anagram window search block, bound to the top level.
module aws_checker import aws_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               match,
	input logic [START_W-1:0] start_index,
	input logic               status
);

	logic [3:0] outstanding_q;

	// Count items accepted whose results are not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
				outstanding_q <= outstanding_q + 1'b1;
			end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
				outstanding_q <= outstanding_q - 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match) && $stable(start_index)
			&& $stable(status))
		else $error("result changed or dropped while stalled");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !match |-> start_index == '0)
		else $error("start index set without a match");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(match && status))
		else $error("match and pattern-full status together");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != '0)
		else $error("result without an accepted item");

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> outstanding_q != '0)
		else $error("input stalled while block is empty");

endmodule

bind anagram_window_search aws_checker u_aws_checker (.*);
